/* rtl/fecs_pkg.sv */
// shared types, constants and the multiply op sequence for the ellipse span block
// no dependencies
package fecs_pkg;

  // field widths
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned RAD_W     = 6;
  localparam int unsigned FILL_W    = 8;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned CHART_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // defaults for the top level parameters
  localparam int unsigned MAX_RADIUS_DEF = 31;
  localparam int unsigned CHART_MAX_DEF  = 1024;
  localparam int unsigned MAX_RESULTS    = 63;

  // internal widths
  localparam int unsigned R_W    = 5;   // saturated radius magnitude
  localparam int unsigned SQ_W   = 10;  // square of a radius
  localparam int unsigned TT_W   = 14;  // (2x+1)^2
  localparam int unsigned X_W    = 6;   // x offset
  localparam int unsigned F_W    = 18;  // stepping terms fx and fy
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned P_W    = 32;  // decision variable, scaled by four
  localparam int unsigned CNT_W  = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHART_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHART_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_PREP2,
    ST_STEP2
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_AA,
    OP_BB,
    OP_AARY,
    OP_TT,
    OP_UU,
    OP_BBTT,
    OP_AAUU,
    OP_AABB
  } op_e;

  // one column pair to be clipped
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [X_W-1:0]            x;
    logic [R_W-1:0]            y;
    logic [FILL_W-1:0]         fill;
    logic                      last;
  } geom_t;

  // one result item
  typedef struct packed {
    logic [COL_W-1:0]  right_col;
    logic              right_ok;
    logic [COL_W-1:0]  left_col;
    logic              left_ok;
    logic [COL_W-1:0]  span_top;
    logic [COL_W-1:0]  span_bottom;
    logic [FILL_W-1:0] fill_out;
    logic              last_span;
  } res_t;

  // multiply sequence: setup chain, then region two chain
  function automatic op_e op_next(op_e op);
    op_e nxt;
    case (op)
      OP_AA:   nxt = OP_BB;
      OP_BB:   nxt = OP_AARY;
      OP_AARY: nxt = OP_NONE;
      OP_TT:   nxt = OP_UU;
      OP_UU:   nxt = OP_BBTT;
      OP_BBTT: nxt = OP_AAUU;
      OP_AAUU: nxt = OP_AABB;
      OP_AABB: nxt = OP_NONE;
      default: nxt = OP_NONE;
    endcase
    return nxt;
  endfunction

endpackage

/* rtl/fecs_if.sv */
// request channels of the ellipse span block: input, result and register write
// depends on fecs_pkg
interface fecs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fecs_pkg::COORD_W-1:0] center_x;
  logic signed [fecs_pkg::COORD_W-1:0] center_y;
  logic signed [fecs_pkg::RAD_W-1:0]   radius_horiz;
  logic signed [fecs_pkg::RAD_W-1:0]   radius_vert;
  logic [fecs_pkg::FILL_W-1:0]         fill_value;

  modport source (output valid, center_x, center_y, radius_horiz, radius_vert, fill_value,
                  input ready);
  modport sink (input valid, center_x, center_y, radius_horiz, radius_vert, fill_value,
                output ready);
endinterface

interface fecs_out_if;
  logic                        valid;
  logic                        ready;
  logic [fecs_pkg::COL_W-1:0]  right_col;
  logic                        right_ok;
  logic [fecs_pkg::COL_W-1:0]  left_col;
  logic                        left_ok;
  logic [fecs_pkg::COL_W-1:0]  span_top;
  logic [fecs_pkg::COL_W-1:0]  span_bottom;
  logic [fecs_pkg::FILL_W-1:0] fill_out;
  logic                        last_span;

  modport source (output valid, right_col, right_ok, left_col, left_ok, span_top,
                  span_bottom, fill_out, last_span, input ready);
  modport sink (input valid, right_col, right_ok, left_col, left_ok, span_top,
                span_bottom, fill_out, last_span, output ready);
endinterface

interface fecs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fecs_pkg::CFG_IDX_W-1:0] addr;
  logic [fecs_pkg::CHART_W-1:0]   data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

/* rtl/filled_ellipse_column_spans.sv */
// top level of the filled ellipse span block: sequencer, walk datapath, registers
// depends on fecs_pkg, fecs_if, fecs_mul, fecs_clip
//
//   channel  modport  direction  carries
//   in_i     sink     in         center_x, center_y, radius_horiz, radius_vert, fill_value
//   out_o    source   out        right_col, right_ok, left_col, left_ok, span_top,
//                                span_bottom, fill_out, last_span
//   cfg_i    sink     in         addr (0 chart_width, 1 chart_height), data
//
// one ellipse is accepted in idle, then runs its setup products on the shared
// multiplier; the walk gives one result per cycle while the result register is
// free, and at the change to region two runs its products and a first step state
// reset: asynchronous active low, chart size back to CHART_MAX, no clearing pass
// a stalled result register holds the walk; register writes are always taken
module filled_ellipse_column_spans #(
  parameter int unsigned MAX_RADIUS = fecs_pkg::MAX_RADIUS_DEF,
  parameter int unsigned CHART_MAX  = fecs_pkg::CHART_MAX_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fecs_in_if.sink      in_i,
  fecs_out_if.source   out_o,
  fecs_cfg_if.sink     cfg_i
);

  localparam int unsigned P_W = fecs_pkg::P_W;
  localparam int unsigned F_W = fecs_pkg::F_W;

  // saturated magnitude of a signed radius
  function automatic logic [fecs_pkg::R_W-1:0] abs_sat(
    logic signed [fecs_pkg::RAD_W-1:0] r
  );
    logic [fecs_pkg::RAD_W:0] mag;
    mag = r[fecs_pkg::RAD_W-1] ? ((fecs_pkg::RAD_W+1)'(0) - {r[fecs_pkg::RAD_W-1], r})
                               : {1'b0, r};
    if (mag > (fecs_pkg::RAD_W+1)'(MAX_RADIUS)) begin
      return fecs_pkg::R_W'(MAX_RADIUS);
    end
    return mag[fecs_pkg::R_W-1:0];
  endfunction

  fecs_pkg::state_e             state_q, state_d;
  fecs_pkg::op_e                op_q, op_d, wb_op;
  logic [fecs_pkg::PROD_W-1:0]  prod;
  logic [fecs_pkg::MUL_W-1:0]   mul_a, mul_b;

  logic signed [fecs_pkg::COORD_W-1:0] cx_q, cy_q;
  logic [fecs_pkg::FILL_W-1:0]         fill_q;
  logic [fecs_pkg::R_W-1:0]            rx_q, ry_q;
  logic [fecs_pkg::SQ_W-1:0]           aa_q, aa_d, bb_q, bb_d, uu_q, uu_d;
  logic [fecs_pkg::TT_W-1:0]           tt_q, tt_d;
  logic [fecs_pkg::X_W-1:0]            x_q, x_d;
  logic [fecs_pkg::R_W-1:0]            y_q, y_d;
  logic [F_W-1:0]                      fx_q, fx_d, fy_q, fy_d;
  logic signed [P_W-1:0]               p_q, p_d;
  logic [fecs_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  logic                                region1_q, region1_d;

  logic [fecs_pkg::CHART_W-1:0] width_q, height_q, cfg_val;
  logic                         out_valid_q, out_valid_d;
  fecs_pkg::res_t               res_q, clip_res;
  fecs_pkg::geom_t              geom;

  logic                  accept, out_free, emit, more, r1_go, p_neg;
  logic [F_W-1:0]        fx_inc, fy_dec;
  logic signed [P_W-1:0] fxi_s, fyd_s, aa_s, bb_s, prod_s, p_r1, p_r2;
  logic [fecs_pkg::X_W:0]   t_val;
  logic [fecs_pkg::R_W-1:0] u_mag;

  // shared multiplier
  fecs_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .op_i   (op_q),
    .prod_o (prod),
    .op_o   (wb_op)
  );

  // clipping of the current column pair
  assign geom.cx   = cx_q;
  assign geom.cy   = cy_q;
  assign geom.x    = x_q;
  assign geom.y    = y_q;
  assign geom.fill = fill_q;
  assign geom.last = !more;

  fecs_clip u_clip (
    .geom_i   (geom),
    .width_i  (width_q),
    .height_i (height_q),
    .res_o    (clip_res)
  );

  // handshakes
  assign in_i.ready  = (state_q == fecs_pkg::ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;
  assign emit        = (state_q == fecs_pkg::ST_WALK) && out_free;

  // region two start terms: t = 2x+1, |y-1|
  assign t_val = {x_q, 1'b1};
  assign u_mag = (y_q == '0) ? fecs_pkg::R_W'(1) : y_q - fecs_pkg::R_W'(1);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      fecs_pkg::OP_AA:   begin mul_a = fecs_pkg::MUL_W'(rx_q); mul_b = fecs_pkg::MUL_W'(rx_q); end
      fecs_pkg::OP_BB:   begin mul_a = fecs_pkg::MUL_W'(ry_q); mul_b = fecs_pkg::MUL_W'(ry_q); end
      fecs_pkg::OP_AARY: begin mul_a = fecs_pkg::MUL_W'(aa_q); mul_b = fecs_pkg::MUL_W'(ry_q); end
      fecs_pkg::OP_TT:   begin mul_a = fecs_pkg::MUL_W'(t_val); mul_b = fecs_pkg::MUL_W'(t_val); end
      fecs_pkg::OP_UU:   begin mul_a = fecs_pkg::MUL_W'(u_mag); mul_b = fecs_pkg::MUL_W'(u_mag); end
      fecs_pkg::OP_BBTT: begin mul_a = fecs_pkg::MUL_W'(bb_q); mul_b = fecs_pkg::MUL_W'(tt_q); end
      fecs_pkg::OP_AAUU: begin mul_a = fecs_pkg::MUL_W'(aa_q); mul_b = fecs_pkg::MUL_W'(uu_q); end
      fecs_pkg::OP_AABB: begin mul_a = fecs_pkg::MUL_W'(aa_q); mul_b = fecs_pkg::MUL_W'(bb_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // step terms shared by both regions
  assign fx_inc = fx_q + F_W'({bb_q, 1'b0});
  assign fy_dec = fy_q - F_W'({aa_q, 1'b0});
  assign fxi_s  = $signed(P_W'(fx_inc));
  assign fyd_s  = $signed(P_W'(fy_dec));
  assign aa_s   = $signed(P_W'(aa_q));
  assign bb_s   = $signed(P_W'(bb_q));
  assign prod_s = $signed(P_W'(prod));
  assign p_neg  = p_q[P_W-1];

  assign p_r1 = p_neg ? p_q + ((fxi_s + bb_s) <<< 2)
                      : p_q + ((fxi_s + bb_s - fyd_s) <<< 2);
  assign p_r2 = p_neg ? p_q + ((fxi_s + aa_s - fyd_s) <<< 2)
                      : p_q + ((aa_s - fyd_s) <<< 2);

  // does another result follow the current one
  assign r1_go = region1_q && (fx_q < fy_q);
  assign more  = (cnt_q != fecs_pkg::CNT_W'(fecs_pkg::MAX_RESULTS - 1)) &&
                 (r1_go || (y_q != '0));

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    aa_d        = aa_q;
    bb_d        = bb_q;
    tt_d        = tt_q;
    uu_d        = uu_q;
    x_d         = x_q;
    y_d         = y_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    region1_d   = region1_q;
    out_valid_d = out_valid_q;

    // product write back
    case (wb_op)
      fecs_pkg::OP_AA:   aa_d = prod[fecs_pkg::SQ_W-1:0];
      fecs_pkg::OP_BB:   bb_d = prod[fecs_pkg::SQ_W-1:0];
      fecs_pkg::OP_AARY: begin
        fy_d = F_W'({prod, 1'b0});
        p_d  = (bb_s <<< 2) - (prod_s <<< 2) + aa_s + $signed(P_W'(2));
      end
      fecs_pkg::OP_TT:   tt_d = prod[fecs_pkg::TT_W-1:0];
      fecs_pkg::OP_UU:   uu_d = prod[fecs_pkg::SQ_W-1:0];
      fecs_pkg::OP_BBTT: p_d  = prod_s + $signed(P_W'(2));
      fecs_pkg::OP_AAUU: p_d  = p_q + (prod_s <<< 2);
      fecs_pkg::OP_AABB: p_d  = p_q - (prod_s <<< 2);
      default: ;
    endcase

    // result register drains when taken
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      fecs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d   = fecs_pkg::ST_SETUP;
          op_d      = fecs_pkg::OP_AA;
          x_d       = '0;
          y_d       = abs_sat(in_i.radius_vert);
          fx_d      = '0;
          cnt_d     = '0;
          region1_d = 1'b1;
        end
      end
      fecs_pkg::ST_SETUP: begin
        op_d = fecs_pkg::op_next(op_q);
        if (op_q == fecs_pkg::OP_NONE) begin
          state_d = fecs_pkg::ST_WALK;
        end
      end
      fecs_pkg::ST_WALK: begin
        if (emit) begin
          out_valid_d = 1'b1;
          cnt_d       = cnt_q + fecs_pkg::CNT_W'(1);
          if (!more) begin
            state_d = fecs_pkg::ST_IDLE;
          end else if (r1_go) begin
            // region one step
            x_d  = x_q + fecs_pkg::X_W'(1);
            fx_d = fx_inc;
            p_d  = p_r1;
            if (!p_neg) begin
              y_d  = y_q - fecs_pkg::R_W'(1);
              fy_d = fy_dec;
            end
          end else if (region1_q) begin
            state_d   = fecs_pkg::ST_PREP2;
            op_d      = fecs_pkg::OP_TT;
            region1_d = 1'b0;
          end else begin
            // region two step
            y_d  = y_q - fecs_pkg::R_W'(1);
            fy_d = fy_dec;
            p_d  = p_r2;
            if (p_neg) begin
              x_d  = x_q + fecs_pkg::X_W'(1);
              fx_d = fx_inc;
            end
          end
        end
      end
      fecs_pkg::ST_PREP2: begin
        op_d = fecs_pkg::op_next(op_q);
        if (op_q == fecs_pkg::OP_NONE) begin
          state_d = fecs_pkg::ST_STEP2;
        end
      end
      fecs_pkg::ST_STEP2: begin
        // first region two step, emitted in the walk state
        y_d     = y_q - fecs_pkg::R_W'(1);
        fy_d    = fy_dec;
        p_d     = p_r2;
        state_d = fecs_pkg::ST_WALK;
        if (p_neg) begin
          x_d  = x_q + fecs_pkg::X_W'(1);
          fx_d = fx_inc;
        end
      end
      default: state_d = fecs_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fecs_pkg::ST_IDLE;
      op_q        <= fecs_pkg::OP_NONE;
      cnt_q       <= '0;
      region1_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      region1_q   <= region1_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    aa_q <= aa_d;
    bb_q <= bb_d;
    tt_q <= tt_d;
    uu_q <= uu_d;
    x_q  <= x_d;
    y_q  <= y_d;
    fx_q <= fx_d;
    fy_q <= fy_d;
    p_q  <= p_d;
    if (accept) begin
      cx_q   <= in_i.center_x;
      cy_q   <= in_i.center_y;
      fill_q <= in_i.fill_value;
      rx_q   <= abs_sat(in_i.radius_horiz);
      ry_q   <= abs_sat(in_i.radius_vert);
    end
    if (emit) begin
      res_q <= clip_res;
    end
  end

  // chart size registers, saturated to the largest chart
  assign cfg_val = (cfg_i.data > fecs_pkg::CHART_W'(CHART_MAX)) ? fecs_pkg::CHART_W'(CHART_MAX)
                                                              : cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= fecs_pkg::CHART_W'(CHART_MAX);
      height_q <= fecs_pkg::CHART_W'(CHART_MAX);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.addr)
        fecs_pkg::CFG_CHART_WIDTH:  width_q  <= cfg_val;
        fecs_pkg::CFG_CHART_HEIGHT: height_q <= cfg_val;
        default: ;
      endcase
    end
  end

  // result outputs
  assign out_o.valid       = out_valid_q;
  assign out_o.right_col   = res_q.right_col;
  assign out_o.right_ok    = res_q.right_ok;
  assign out_o.left_col    = res_q.left_col;
  assign out_o.left_ok     = res_q.left_ok;
  assign out_o.span_top    = res_q.span_top;
  assign out_o.span_bottom = res_q.span_bottom;
  assign out_o.fill_out    = res_q.fill_out;
  assign out_o.last_span   = res_q.last_span;

`ifndef ASSERT_OFF
  // a request starts the setup chain at its first op
  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == fecs_pkg::ST_SETUP) && (op_q == fecs_pkg::OP_AA))
    else $error("setup did not start after a request");

  // the last result of an ellipse returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !more) |=> (state_q == fecs_pkg::ST_IDLE) && out_valid_q && res_q.last_span)
    else $error("last result did not end the walk");

  // a region two step never runs below the axis
  a_step2_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fecs_pkg::ST_STEP2) |-> (y_q != '0))
    else $error("region two step with y at zero");

  // result count stays below the step limit while walking
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fecs_pkg::ST_WALK) |-> (cnt_q < fecs_pkg::CNT_W'(fecs_pkg::MAX_RESULTS)))
    else $error("result count beyond the step limit");

  // a waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !emit)
    else $error("result register overwritten while waiting");
`endif

endmodule

/* rtl/fecs_mul.sv */
// shared registered multiplier of the ellipse span block, tags each product with its op
// depends on fecs_pkg
module fecs_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fecs_pkg::MUL_W-1:0]    a_i,
  input  logic [fecs_pkg::MUL_W-1:0]    b_i,
  input  fecs_pkg::op_e                 op_i,
  output logic [fecs_pkg::PROD_W-1:0]   prod_o,
  output fecs_pkg::op_e                 op_o
);

  logic [fecs_pkg::PROD_W-1:0] prod_d, prod_q;
  fecs_pkg::op_e               op_q;

  // unsigned product, result width holds the full product
  assign prod_d = a_i * b_i;

  // product register, payload only
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // op tag register, reset, in step with the product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= fecs_pkg::OP_NONE;
    end else begin
      op_q <= op_i;
    end
  end

  assign prod_o = prod_q;
  assign op_o   = op_q;

endmodule

/* rtl/fecs_clip.sv */
// clips one mirrored column pair and its vertical span to the chart
// depends on fecs_pkg
module fecs_clip (
  input  fecs_pkg::geom_t                geom_i,
  input  logic [fecs_pkg::CHART_W-1:0]   width_i,
  input  logic [fecs_pkg::CHART_W-1:0]   height_i,
  output fecs_pkg::res_t                 res_o
);

  localparam int unsigned S_W = fecs_pkg::COORD_W + 2;

  logic signed [S_W-1:0] cx_s, cy_s, x_s, y_s, w_s, h_m1;
  logic signed [S_W-1:0] r, l, top, bot, top_c, bot_c;
  logic                  span, rok, lok;

  // widen everything to one signed width
  assign cx_s = S_W'(geom_i.cx);
  assign cy_s = S_W'(geom_i.cy);
  assign x_s  = $signed(S_W'(geom_i.x));
  assign y_s  = $signed(S_W'(geom_i.y));
  assign w_s  = $signed(S_W'(width_i));
  assign h_m1 = $signed(S_W'(height_i)) - $signed(S_W'(1));

  // mirrored columns and raw span
  assign r   = cx_s + x_s;
  assign l   = cx_s - x_s;
  assign top = cy_s - y_s;
  assign bot = cy_s + y_s;

  // clip span to the chart rows
  assign top_c = top[S_W-1] ? '0 : top;
  assign bot_c = (bot > h_m1) ? h_m1 : bot;
  assign span  = (height_i != '0) && (top_c <= bot_c);

  // column checks
  assign rok = span && !r[S_W-1] && (r < w_s);
  assign lok = span && !l[S_W-1] && (l < w_s);

  always_comb begin
    res_o.right_col   = rok ? r[fecs_pkg::COL_W-1:0] : '0;
    res_o.right_ok    = rok;
    res_o.left_col    = lok ? l[fecs_pkg::COL_W-1:0] : '0;
    res_o.left_ok     = lok;
    res_o.span_top    = span ? top_c[fecs_pkg::COL_W-1:0] : '0;
    res_o.span_bottom = span ? bot_c[fecs_pkg::COL_W-1:0] : '0;
    res_o.fill_out    = geom_i.fill;
    res_o.last_span   = geom_i.last;
  end

endmodule
